// ===== design/plm_pkg.sv =====
// ----------------------------------------------------------------------------
// plm_pkg
// shared constants for the piecewise-linear table map: command and register
// codes, scale reset value, divider widths
// ----------------------------------------------------------------------------
`default_nettype none

package plm_pkg;

    // command carried in tuser
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // configuration register indexes
    localparam int          CFG_INDEX_W    = 2;
    localparam logic [1:0]  CFG_CELL_COUNT = 2'd0;
    localparam logic [1:0]  CFG_OFFSET     = 2'd1;
    localparam logic [1:0]  CFG_SCALE      = 2'd2;

    localparam logic signed [15:0] SCALE_RESET = 16'sd256;

    // rounding divider: dividend is 2*|num| + |den|, divisor is 2*|den|
    localparam int DIVIDEND_W = 42;
    localparam int DIVISOR_W  = 17;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_STEP_W = $clog2(DIV_STEPS);

endpackage

`default_nettype wire

// ===== design/piecewise_linear_table_map_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_map_unit
// piecewise-linear lookup table with interpolation, offset, gain and
// saturation to a signed 32-bit result with 8 fraction bits
// ----------------------------------------------------------------------------
// One item is in work at a time. A write item (tuser = 1) stores one cell
// {breakpoint, cell_value} in the table memory and gives no result. A
// lookup item (tuser = 0) gives one result. With fewer than two cells in
// use x passes straight through. Otherwise the segment search reads one
// cell per cycle from the table memory (one write port, one read port),
// upper breakpoints from cell 1 up to the chosen segment, and the rounding
// divide runs bit-serially, one quotient bit per cycle over 42 bits; a
// zero-width segment skips the divide. A new item is taken as soon as the
// result is in the output register, which holds it until the master side
// takes it. Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_table_map_unit #(
    parameter int MAX_CELLS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] cell_index, [19:4] breakpoint, [35:20] cell_value,
    // [51:36] x_value, [55:52] zero
    input  wire logic [55:0] s_tdata,
    // [0] command
    input  wire logic        s_tuser,

    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] mapped_value
    output logic [31:0]      m_tdata,
    // [0] saturated
    output logic             m_tuser,

    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [plm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [15:0]                      cfg_data
);

    localparam int AW = $clog2(MAX_CELLS);

    // one-hot sequencer states
    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_SCAN   = 13'b0000000000010,
        ST_LOAD   = 13'b0000000000100,
        ST_MULT   = 13'b0000000001000,
        ST_PREP   = 13'b0000000010000,
        ST_DIVIDE = 13'b0000000100000,
        ST_VALUE  = 13'b0000001000000,
        ST_OFFSET = 13'b0000010000000,
        ST_MUL_LO = 13'b0000100000000,
        ST_MUL_HI = 13'b0001000000000,
        ST_ROUND  = 13'b0010000000000,
        ST_SIGN   = 13'b0100000000000,
        ST_FINISH = 13'b1000000000000
    } state_t;

    // configuration registers
    logic [4:0]         cell_count_reg;
    logic signed [15:0] offset_reg;
    logic signed [15:0] scale_reg;

    // input field slices
    logic [3:0]         in_index;
    logic [15:0]        in_breakpoint;
    logic [15:0]        in_value;
    logic signed [15:0] in_x;

    assign in_index      = s_tdata[3:0];
    assign in_breakpoint = s_tdata[19:4];
    assign in_value      = s_tdata[35:20];
    assign in_x          = $signed(s_tdata[51:36]);

    // table memory: [31:16] breakpoint, [15:0] cell value
    logic [31:0]        table_mem [MAX_CELLS];
    logic [31:0]        rd_data_reg;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;

    // sequencer and datapath registers
    state_t             state_reg, state_next;
    logic [4:0]         n_reg, n_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [15:0] x_reg, x_next;
    logic signed [15:0] x0_reg, x0_next;
    logic signed [15:0] x1_reg, x1_next;
    logic signed [15:0] y0_reg, y0_next;
    logic signed [15:0] y1_reg, y1_next;
    logic signed [16:0] d_reg, d_next;
    logic signed [33:0] prod_reg, prod_next;
    logic               neg_reg, neg_next;
    logic signed [43:0] v_reg, v_next;
    logic signed [43:0] t_reg, t_next;
    logic signed [40:0] plo_reg, plo_next;
    logic signed [59:0] p_reg, p_next;
    logic [59:0]        mag_reg, mag_next;
    logic [31:0]        res_reg, res_next;
    logic               res_sat_reg, res_sat_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_data_reg, m_data_next;
    logic               m_sat_reg, m_sat_next;

    // divider hookup
    logic                               div_start;
    logic [plm_pkg::DIVIDEND_W-1:0]     div_dividend;
    logic [plm_pkg::DIVISOR_W-1:0]      div_divisor;
    logic [plm_pkg::DIVIDEND_W-1:0]     div_quotient;
    logic                               div_done;

    // combinational helpers
    logic               in_accept;
    logic [4:0]         n_eff;
    logic               scan_stop;
    logic [4:0]         scan_addr;
    logic [AW+4:0]      rd_wide;
    logic [AW+3:0]      wr_wide;
    logic signed [16:0] dx, dy;
    logic [33:0]        prod_mag;
    logic [16:0]        d_mag;
    logic [43:0]        q_signed;
    logic signed [24:0] t_lo;
    logic signed [19:0] t_hi;
    logic signed [35:0] phi;
    logic [51:0]        q_round;
    logic               out_free;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    // cell count clipped to the table depth
    assign n_eff = ({4'b0000, cell_count_reg} > 9'(MAX_CELLS)) ? 5'(MAX_CELLS)
                                                             : cell_count_reg;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg <= '0;
            offset_reg     <= '0;
            scale_reg      <= plm_pkg::SCALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                plm_pkg::CFG_CELL_COUNT: cell_count_reg <= cfg_data[4:0];
                plm_pkg::CFG_OFFSET:     offset_reg     <= $signed(cfg_data);
                plm_pkg::CFG_SCALE:      scale_reg      <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // memory write: index beyond the table is dropped
    assign wr_wide = {{AW{1'b0}}, in_index};
    assign wr_addr = wr_wide[AW-1:0];
    assign mem_we  = in_accept && (s_tuser == plm_pkg::CMD_WRITE)
                     && ({5'b00000, in_index} < 9'(MAX_CELLS));

    // segment stops at the first cell whose breakpoint is above x, or at the end
    assign scan_stop = ($signed(rd_data_reg[31:16]) > x_reg)
                       || (cnt_reg == (n_reg - 5'd2));

    // read address: next breakpoint during the scan, lower cell once found
    always_comb begin
        rd_en     = 1'b0;
        scan_addr = 5'd1;
        if (state_reg == ST_IDLE) begin
            rd_en     = 1'b1;
            scan_addr = 5'd1;
        end else if (state_reg == ST_SCAN) begin
            rd_en     = 1'b1;
            scan_addr = scan_stop ? cnt_reg : (cnt_reg + 5'd2);
        end
        rd_wide = {{AW{1'b0}}, scan_addr};
        rd_addr = rd_wide[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[wr_addr] <= {in_breakpoint, in_value};
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // arithmetic pieces
    always_comb begin
        dx       = {x_reg[15], x_reg} - {x0_reg[15], x0_reg};
        dy       = {y1_reg[15], y1_reg} - {y0_reg[15], y0_reg};
        prod_mag = prod_reg[33] ? (34'd0 - prod_reg) : prod_reg;
        d_mag    = d_reg[16] ? (17'd0 - d_reg) : d_reg;
        // 2*|num| + |den| with num = prod*256, and 2*|den|
        div_dividend = {1'b0, prod_mag[31:0], 9'b0} + {26'b0, d_mag[15:0]};
        div_divisor  = {d_mag[15:0], 1'b0};
        q_signed = neg_reg ? (44'd0 - {2'b00, div_quotient}) : {2'b00, div_quotient};
        t_lo     = $signed({1'b0, t_reg[23:0]});
        t_hi     = t_reg[43:24];
        phi      = t_hi * scale_reg;
        q_round  = mag_reg[59:8];
    end

    assign div_start = (state_reg == ST_PREP) && (d_reg != 17'sd0);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        x0_next      = x0_reg;
        x1_next      = x1_reg;
        y0_next      = y0_reg;
        y1_next      = y1_reg;
        d_next       = d_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        v_next       = v_reg;
        t_next       = t_reg;
        plo_next     = plo_reg;
        p_next       = p_reg;
        mag_next     = mag_reg;
        res_next     = res_reg;
        res_sat_next = res_sat_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_sat_next   = m_sat_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_tuser == plm_pkg::CMD_LOOKUP)) begin
                    x_next   = in_x;
                    n_next   = n_eff;
                    cnt_next = 5'd0;
                    if (n_eff < 5'd2) begin
                        // pass-through: no offset, no gain
                        res_next     = {{8{in_x[15]}}, in_x, 8'b0};
                        res_sat_next = 1'b0;
                        state_next   = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_stop) begin
                    x1_next    = $signed(rd_data_reg[31:16]);
                    y1_next    = $signed(rd_data_reg[15:0]);
                    state_next = ST_LOAD;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_LOAD: begin
                x0_next    = $signed(rd_data_reg[31:16]);
                y0_next    = $signed(rd_data_reg[15:0]);
                state_next = ST_MULT;
            end
            ST_MULT: begin
                prod_next  = dx * dy;
                d_next     = {x1_reg[15], x1_reg} - {x0_reg[15], x0_reg};
                state_next = ST_PREP;
            end
            ST_PREP: begin
                neg_next = prod_reg[33] ^ d_reg[16];
                if (d_reg == 17'sd0) begin
                    // zero-width segment maps to x itself
                    v_next     = {{20{x_reg[15]}}, x_reg, 8'b0};
                    state_next = ST_OFFSET;
                end else begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_VALUE;
                end
            end
            ST_VALUE: begin
                v_next     = $signed({{20{y0_reg[15]}}, y0_reg, 8'b0}) + $signed(q_signed);
                state_next = ST_OFFSET;
            end
            ST_OFFSET: begin
                t_next     = v_reg + $signed({{20{offset_reg[15]}}, offset_reg, 8'b0});
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                plo_next   = t_lo * scale_reg;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                p_next     = $signed({phi, 24'b0}) + $signed({{19{plo_reg[40]}}, plo_reg});
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                // |p| + 128, halves away from zero after the shift
                neg_next   = p_reg[59];
                mag_next   = p_reg[59] ? (~p_reg + 60'd129) : (p_reg + 60'd128);
                state_next = ST_SIGN;
            end
            ST_SIGN: begin
                if (!neg_reg && (q_round > 52'h0_0000_7FFF_FFFF)) begin
                    res_next     = 32'h7FFF_FFFF;
                    res_sat_next = 1'b1;
                end else if (neg_reg && (q_round > 52'h0_0000_8000_0000)) begin
                    res_next     = 32'h8000_0000;
                    res_sat_next = 1'b1;
                end else begin
                    res_next     = neg_reg ? (32'd0 - q_round[31:0]) : q_round[31:0];
                    res_sat_next = 1'b0;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_sat_next   = res_sat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        cnt_reg     <= cnt_next;
        x_reg       <= x_next;
        x0_reg      <= x0_next;
        x1_reg      <= x1_next;
        y0_reg      <= y0_next;
        y1_reg      <= y1_next;
        d_reg       <= d_next;
        prod_reg    <= prod_next;
        neg_reg     <= neg_next;
        v_reg       <= v_next;
        t_reg       <= t_next;
        plo_reg     <= plo_next;
        p_reg       <= p_next;
        mag_reg     <= mag_next;
        res_reg     <= res_next;
        res_sat_reg <= res_sat_next;
        m_data_reg  <= m_data_next;
        m_sat_reg   <= m_sat_next;
    end

    // bit-serial rounding divider
    plm_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

`ifndef SYNTHESIS
    a_scan_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> ((cnt_reg + 5'd1) < n_reg))
        else $error("segment scan ran past the last cell");

    a_sat_is_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_sat_reg) |->
            ((m_data_reg == 32'h7FFF_FFFF) || (m_data_reg == 32'h8000_0000)))
        else $error("saturated result is not a range limit");

    a_div_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide step");
`endif

endmodule

`default_nettype wire

// ===== design/plm_divider.sv =====
// ----------------------------------------------------------------------------
// plm_divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module plm_divider (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [plm_pkg::DIVIDEND_W-1:0]      dividend,
    input  wire logic [plm_pkg::DIVISOR_W-1:0]       divisor,
    output logic      [plm_pkg::DIVIDEND_W-1:0]      quotient,
    output logic                                     done
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [plm_pkg::DIV_STEP_W-1:0]      step_reg;
    logic [plm_pkg::DIVISOR_W-1:0]       rem_reg;
    logic [plm_pkg::DIVISOR_W-1:0]       dvs_reg;
    logic [plm_pkg::DIVIDEND_W-1:0]      quo_reg;

    logic [plm_pkg::DIVISOR_W:0]         shifted;
    logic [plm_pkg::DIVISOR_W+1:0]       diff;
    logic                                ge;

    always_comb begin
        shifted = {rem_reg, quo_reg[plm_pkg::DIVIDEND_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        ge      = ~diff[plm_pkg::DIVISOR_W+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == plm_pkg::DIV_STEP_W'(plm_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[plm_pkg::DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? diff[plm_pkg::DIVISOR_W-1:0] : shifted[plm_pkg::DIVISOR_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a finished run");
`endif

endmodule

`default_nettype wire

// ===== test/plm_map_checker.sv =====
// ----------------------------------------------------------------------------
// plm_map_checker
// watches the item, result and configuration channels of the table map unit,
// keeps its own copy of the table and registers, predicts each lookup result
// and compares the results in order, field by field
// ----------------------------------------------------------------------------
module plm_map_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [55:0]                     s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [31:0]                     m_tdata,
    input  wire logic                            m_tuser,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [plm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]                     cfg_data,
    output int                                   mismatch_count,
    output int                                   results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] mapped_value;
        logic        saturated;
    } map_result_t;

    map_result_t owed_q[$];

    logic signed [15:0] bp_mem [TABLE_DEPTH];
    logic signed [15:0] val_mem [TABLE_DEPTH];
    logic [4:0]         cells_cfg;
    logic signed [15:0] offset_cfg;
    logic signed [15:0] scale_cfg;

    // nearest, halves away from zero
    function automatic longint round_div(longint num, longint den);
        longint an;
        longint ad;
        longint q;
        bit     neg;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        q   = (2 * an + ad) / (2 * ad);
        return neg ? -q : q;
    endfunction

    function automatic map_result_t map_lookup(logic signed [15:0] x);
        int          n;
        int          lo;
        longint      xv, x0, x1, y0, y1, d, v, t, r;
        map_result_t res;
        xv = x;
        n  = (cells_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(cells_cfg);
        if (n < 2) begin
            res.mapped_value = 32'(xv * 256);
            res.saturated    = 1'b0;
            return res;
        end
        // lowest segment whose upper breakpoint lies above x, else the last one
        lo = n - 2;
        for (int i = n - 2; i >= 0; i--) begin
            if (bp_mem[i + 1] > x) lo = i;
        end
        x0 = bp_mem[lo];
        x1 = bp_mem[lo + 1];
        y0 = val_mem[lo];
        y1 = val_mem[lo + 1];
        d  = x1 - x0;
        if (d == 0) v = xv * 256;
        else v = y0 * 256 + round_div((xv - x0) * (y1 - y0) * 256, d);
        t = v + longint'(offset_cfg) * 256;
        r = round_div(t * longint'(scale_cfg), 256);
        res.saturated = 1'b0;
        if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            res.saturated = 1'b1;
        end else if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            res.saturated = 1'b1;
        end
        res.mapped_value = r[31:0];
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        map_result_t want;
        if (!aresetn) begin
            owed_q.delete();
            cells_cfg  = '0;
            offset_cfg = '0;
            scale_cfg  = plm_pkg::SCALE_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_q.size() == 0) begin
                    mismatch_count++;
                    $error("unexpected result item: mapped_value %0d saturated %0b",
                           $signed(m_tdata), m_tuser);
                end else begin
                    want = owed_q.pop_front();
                    if (m_tdata !== want.mapped_value) begin
                        mismatch_count++;
                        $error("mapped_value mismatch: expected %0d, actual %0d",
                               $signed(want.mapped_value), $signed(m_tdata));
                    end
                    if (m_tuser !== want.saturated) begin
                        mismatch_count++;
                        $error("saturated mismatch: expected %0b, actual %0b",
                               want.saturated, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == plm_pkg::CMD_WRITE) begin
                    bp_mem[s_tdata[3:0]]  = s_tdata[19:4];
                    val_mem[s_tdata[3:0]] = s_tdata[35:20];
                end else begin
                    owed_q.push_back(map_lookup(s_tdata[51:36]));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    plm_pkg::CFG_CELL_COUNT: cells_cfg  = cfg_data[4:0];
                    plm_pkg::CFG_OFFSET:     offset_cfg = cfg_data;
                    plm_pkg::CFG_SCALE:      scale_cfg  = cfg_data;
                    default: ;
                endcase
            end
        end
        results_owed <= owed_q.size();
    end

endmodule

// ===== test/piecewise_linear_table_map_unit_tb.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_map_unit_tb
// drives table writes, lookups and register writes into the table map unit:
// a directed pass over passthrough, segment edges, zero-width and unordered
// segments and saturation, then random phases with fresh tables and settings,
// random idling on both sides, one long result hold-off; checking is done by
// plm_map_checker
// ----------------------------------------------------------------------------
module piecewise_linear_table_map_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 16;
    localparam int ITEM_TARGET  = 1950;
    localparam int SETTLE_WAIT  = 100;      // well past the slowest lookup
    localparam int HOLD_CYCLES  = 400;      // long result hold-off
    localparam int HOLD_AFTER   = 300;      // items sent before the hold-off
    localparam int CYCLE_LIMIT  = 1000000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // item channel
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;     // [3:0] cell_index, [19:4] breakpoint,
                                    // [35:20] cell_value, [51:36] x_value
    logic        s_tuser  = 1'b0;   // [0] command

    // result channel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] mapped_value
    logic        m_tuser;           // [0] saturated

    // register write channel
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [plm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]                     cfg_data  = '0;

    int mismatch_count;
    int results_owed;
    int items_sent  = 0;
    int cycle_count = 0;

    // stimulus-side shadow of the breakpoints, used to aim x values
    logic signed [15:0] bp_shadow [TABLE_DEPTH];

    logic idle_on    = 1'b1;    // random gaps on both sides
    logic stall_req  = 1'b0;    // asks the receiver for one long hold-off
    bit   stall_done = 1'b0;

    piecewise_linear_table_map_unit #(
        .MAX_CELLS (TABLE_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    plm_map_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random back-pressure, one long hold-off on request
    always @(posedge aclk) begin
        if (stall_req && !stall_done) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            stall_done = 1'b1;
        end else if (idle_on) begin
            m_tready <= ($urandom_range(99) >= 18);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // offer one item and wait for it to be taken, with an optional gap first
    task automatic push_item(logic cmd, logic [3:0] idx, logic [15:0] bp,
                             logic [15:0] val, logic [15:0] x);
        if (idle_on && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, x, val, bp, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic write_cell(int idx, logic signed [15:0] bp, logic signed [15:0] val);
        bp_shadow[idx] = bp;
        push_item(plm_pkg::CMD_WRITE, idx[3:0], bp, val, 16'($urandom));
    endtask

    // other fields of a lookup carry noise so their bits move
    task automatic lookup(logic signed [15:0] x);
        push_item(plm_pkg::CMD_LOOKUP, 4'($urandom), 16'($urandom), 16'($urandom), x);
    endtask

    // stop sending until every result is back and the unit has gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic set_reg(logic [plm_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // write cells 0..cells-1 in one of several shapes
    task automatic build_map(int cells, int shape);
        shortint pts[$];
        shortint base;
        int      step;
        base = shortint'($urandom);
        for (int k = 0; k < cells; k++) begin
            case (shape)
                1: begin
                    // narrow ascending run, frequent zero-width segments
                    pts.push_back(base);
                    step = $urandom_range(0, 40);
                    if (step < 8) step = 0;
                    base = base + shortint'(step);
                end
                default: pts.push_back(shortint'($urandom));
            endcase
        end
        if (shape == 0 || shape == 3) pts.sort();
        if (shape == 3) begin
            pts[0]         = -32768;
            pts[cells - 1] = 32767;
        end
        // shape 2 stays unordered
        for (int k = 0; k < cells; k++) begin
            if (shape == 3) write_cell(k, pts[k], (k % 2) ? 16'sd32767 : -16'sd32768);
            else write_cell(k, pts[k], 16'($urandom));
        end
    endtask

    // x values: anywhere, close to a breakpoint, on one, or at an extreme
    function automatic logic signed [15:0] pick_x(int cells);
        int                 r;
        int                 k;
        logic signed [15:0] delta;
        r = $urandom_range(99);
        k = (cells > 0) ? $urandom_range(cells - 1) : 0;
        if (cells < 2 || r < 35) return 16'($urandom);
        if (r < 70) begin
            delta = 16'($urandom_range(8));
            return bp_shadow[k] + delta - 16'sd4;
        end
        if (r < 85) return bp_shadow[k];
        return (r < 93) ? -16'sd32768 : 16'sd32767;
    endfunction

    initial begin : stimulus
        int count_sel;
        int map_cells;
        int r;
        logic [15:0] offset_val;
        logic [15:0] scale_val;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // no cells in use: x passes straight through
        lookup(-16'sd32768);
        lookup(16'sd32767);
        lookup(16'sd0);
        lookup(16'sd1);
        drain();
        set_reg(plm_pkg::CFG_CELL_COUNT, 16'd1);
        lookup(-16'sd1);

        // four-cell map spanning the whole range with extreme values
        write_cell(0, -16'sd32768, 16'sd32767);
        write_cell(1, -16'sd256, -16'sd32768);
        write_cell(2, 16'sd256, 16'sd32767);
        write_cell(3, 16'sd32767, -16'sd32768);
        drain();
        set_reg(plm_pkg::CFG_CELL_COUNT, 16'd4);
        // first breakpoint, inside segments, exact breakpoints, last breakpoint
        lookup(-16'sd32768);
        lookup(-16'sd1000);
        lookup(-16'sd256);
        lookup(16'sd0);
        lookup(16'sd256);
        lookup(16'sd1000);
        lookup(16'sd32767);

        // equal first breakpoints, x below them: zero-width segment
        write_cell(0, 16'sd0, 16'sd32767);
        write_cell(1, 16'sd0, -16'sd32768);
        lookup(-16'sd5);
        // last breakpoint below the one before it: negative segment width
        write_cell(3, -16'sd1000, -16'sd32768);
        lookup(16'sd5000);

        // most negative offset and gain: drives the result into saturation
        drain();
        set_reg(plm_pkg::CFG_OFFSET, 16'h8000);
        set_reg(plm_pkg::CFG_SCALE, 16'h8000);
        lookup(-16'sd32768);
        lookup(16'sd32767);

        // ---- random phases ----
        while (items_sent < ITEM_TARGET) begin
            drain();
            // one stretch with no idling on either side
            idle_on <= !(items_sent >= 700 && items_sent < 1000);

            count_sel = $urandom_range(9);
            case (count_sel)
                0: map_cells = 0;
                1: map_cells = 1;
                2: map_cells = 2;
                3: map_cells = TABLE_DEPTH;
                4: map_cells = $urandom_range(17, 31);   // clamps to the depth
                default: map_cells = $urandom_range(3, 15);
            endcase

            r = $urandom_range(99);
            if (r < 10) offset_val = 16'h8000;
            else if (r < 20) offset_val = 16'h7fff;
            else if (r < 30) offset_val = 16'h0000;
            else offset_val = 16'($urandom);

            r = $urandom_range(99);
            if (r < 8) scale_val = 16'd256;
            else if (r < 15) scale_val = 16'h0000;
            else if (r < 22) scale_val = 16'h8000;
            else if (r < 29) scale_val = 16'h7fff;
            else if (r < 35) scale_val = 16'hff00;
            else if (r < 40) scale_val = 16'h0001;
            else scale_val = 16'($urandom);

            set_reg(plm_pkg::CFG_CELL_COUNT, 16'(map_cells));
            set_reg(plm_pkg::CFG_OFFSET, offset_val);
            set_reg(plm_pkg::CFG_SCALE, scale_val);

            if (map_cells > TABLE_DEPTH) map_cells = TABLE_DEPTH;
            // every cell a lookup can reach is written before the lookups
            if (map_cells >= 2) build_map(map_cells, $urandom_range(3));
            else if ($urandom_range(1)) write_cell($urandom_range(15), 16'($urandom),
                                                   16'($urandom));

            // hold-off starts while a full phase of lookups is still to come
            if (items_sent >= HOLD_AFTER) stall_req <= 1'b1;

            repeat ($urandom_range(30, 80)) begin
                // occasional stray write that reshapes the map mid-phase
                if ($urandom_range(99) < 6)
                    write_cell($urandom_range(15), 16'($urandom), 16'($urandom));
                else
                    lookup(pick_x(map_cells));
            end
        end

        // ---- wind down and verdict ----
        drain();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
